// ===== hw/rtl/plst_pkg.sv =====
// plst_pkg: shared types, codes and widths for the positional list store
// used by plst_cell and positional_list_store_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package plst_pkg;

   localparam int VALUE_W           = 32;
   localparam int POS_W             = 8;
   localparam int COUNT_W           = 5;
   localparam int STATUS_W          = 2;
   localparam int OP_W              = 2;
   localparam int MAX_ENTRIES_DEF   = 16;
   localparam logic [COUNT_W-1:0] CAPACITY_RESET = COUNT_W'(16);

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_GET    = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY_POS = 2'd2
   } status_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic               shift_up;
      logic               shift_down;
      logic [POS_W-1:0]   slot;
      logic [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/plst_cell.sv =====
// plst_cell: one storage cell of the list row, shifts with its neighbors
// and passes the read bus along the row; depends on plst_pkg
`timescale 1ns / 1ps
`default_nettype none

module plst_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                          clock,
   input  wire plst_pkg::cell_cmd_type        cmd,
   input  wire logic [plst_pkg::VALUE_W-1:0]  left_value,
   input  wire logic [plst_pkg::VALUE_W-1:0]  right_value,
   input  wire logic [plst_pkg::VALUE_W-1:0]  rd_chain_in,
   output logic      [plst_pkg::VALUE_W-1:0]  cell_value,
   output logic      [plst_pkg::VALUE_W-1:0]  rd_chain_out
);
   import plst_pkg::*;

   localparam logic [POS_W-1:0] CELL_POS = POS_W'(INDEX);

   logic [VALUE_W-1:0] val_ff;
   logic [VALUE_W-1:0] val_in;
   logic               hit;

   assign hit = (cmd.slot == CELL_POS);

   always_comb begin
      val_in = val_ff;
      if (cmd.shift_up) begin
         if (CELL_POS > cmd.slot) begin
            val_in = left_value;
         end else if (hit) begin
            val_in = cmd.value;
         end
      end else if (cmd.shift_down) begin
         if (CELL_POS >= cmd.slot) begin
            val_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign cell_value   = val_ff;
   assign rd_chain_out = hit ? (rd_chain_in | val_ff) : rd_chain_in;

endmodule

`default_nettype wire

// ===== hw/rtl/positional_list_store_top.sv =====
// positional_list_store_top: ordered list of 32-bit entries in a row of cells
// depends on plst_pkg and plst_cell
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to MAX_ENTRIES 32-bit entries held in a row of shift
// cells. Each operation (insert, get, delete, clear) is one transfer on the
// req_ channel and gives one transfer on the rsp_ channel with status, value
// read and entry count. On insert or delete the cells at and above the slot
// shift up or down in the accepting cycle and the result lands in the output
// register, so a new item is taken every cycle while the output register is
// free or being taken. csr_wr_en writes the capacity register (reset 16;
// full caps it at MAX_ENTRIES); write it only while no item is in flight.
module positional_list_store_top #(
   parameter int MAX_ENTRIES = plst_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [plst_pkg::OP_W-1:0]       req_operation,
   input  wire logic [plst_pkg::POS_W-1:0]      req_position,
   input  wire logic [plst_pkg::VALUE_W-1:0]    req_entry_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [plst_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [plst_pkg::VALUE_W-1:0]    rsp_read_value,
   output logic      [plst_pkg::COUNT_W-1:0]    rsp_entry_count,
   input  wire logic                            csr_wr_en,
   input  wire logic [plst_pkg::COUNT_W-1:0]    csr_wr_data
);
   import plst_pkg::*;

   localparam int CMP_W = POS_W + 1;
   localparam logic [CMP_W-1:0] MAX_X = CMP_W'(MAX_ENTRIES);

   logic [COUNT_W-1:0]  capacity_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [STATUS_W-1:0] rsp_status_in;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic [VALUE_W-1:0]  rsp_value_in;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic                accept;
   op_type              op;
   logic [CMP_W-1:0]    cnt_x;
   logic [CMP_W-1:0]    cap_x;
   logic [CMP_W-1:0]    pos_x;
   logic                full;
   logic                miss;
   cell_cmd_type        cmd;

   logic [VALUE_W-1:0]  cell_val [MAX_ENTRIES];
   logic [VALUE_W-1:0]  rd_chain [MAX_ENTRIES+1];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign op        = op_type'(req_operation);

   assign cnt_x = CMP_W'(count_ff);
   assign cap_x = CMP_W'(capacity_ff);
   assign pos_x = CMP_W'(req_position);
   assign full  = (cnt_x >= cap_x) || (cnt_x >= MAX_X);
   assign miss  = (pos_x >= cnt_x) || (pos_x >= MAX_X);

   always_comb begin
      cmd.shift_up   = 1'b0;
      cmd.shift_down = 1'b0;
      cmd.slot       = req_position;
      cmd.value      = req_entry_value;
      count_in       = count_ff;
      rsp_status_in  = ST_OK;
      rsp_value_in   = '0;
      unique case (op)
         OP_INSERT: begin
            if (pos_x > cnt_x) begin
               cmd.slot = POS_W'(count_ff);
            end
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               cmd.shift_up = accept;
               count_in     = count_ff + COUNT_W'(1);
            end
         end
         OP_GET, OP_DELETE: begin
            if (miss) begin
               rsp_status_in = ST_EMPTY_POS;
            end else begin
               rsp_value_in = rd_chain[MAX_ENTRIES];
               if (op == OP_DELETE) begin
                  cmd.shift_down = accept;
                  count_in       = count_ff - COUNT_W'(1);
               end
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // row of cells, read bus chained from cell 0 upward
   assign rd_chain[0] = '0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [VALUE_W-1:0] left_v;
      logic [VALUE_W-1:0] right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_left
         assign left_v = cell_val[i-1];
      end
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign right_v = cell_val[i];
      end else begin : g_right
         assign right_v = cell_val[i+1];
      end
      plst_cell #(
         .INDEX (i)
      ) u_cell (
         .clock        (clock),
         .cmd          (cmd),
         .left_value   (left_v),
         .right_value  (right_v),
         .rd_chain_in  (rd_chain[i]),
         .cell_value   (cell_val[i]),
         .rd_chain_out (rd_chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

`default_nettype wire
